// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the digit sprite emitter.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, switched off while reset is asserted
`define DDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds through reset
`define DDS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDS_ASSERT(lbl, clk, rstn, prop, msg)
`define DDS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/dds_pkg.sv
// Shared types and constants for the decimal digit sprite emitter.
// No dependencies; used by the interfaces, controller, datapath and top level.
package dds_pkg;

  // Display geometry and digit limits
  localparam int MAX_DIGITS    = 10;
  localparam int WINDOW_WIDTH  = 320;
  localparam int WINDOW_HEIGHT = 240;

  // Field widths
  localparam int BIN_W      = 32;
  localparam int CNT_W      = 4;
  localparam int POS_W      = 16;
  localparam int DX_W       = 17;
  localparam int GLYPH_W    = 10;
  localparam int ORIGIN_W   = 12;
  localparam int SRC_X_W    = 14;
  localparam int DIGIT_W    = 4;
  localparam int BIT_CNT_W  = $clog2(BIN_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_STRIP_X      = 3'd2,
    REG_STRIP_Y      = 3'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } dds_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;
    logic conv_last;
    logic emit_last;
  } dp_sts_t;

endpackage

// File: rtl/core/dds_in_if.sv
// Input request channel of the digit sprite emitter.
// Depends on dds_pkg for field widths.
interface dds_in_if import dds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [BIN_W-1:0] number;
  logic [CNT_W-1:0]        digit_count;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (output valid, number, digit_count, pos_x, pos_y, input ready);
  modport sink   (input valid, number, digit_count, pos_x, pos_y, output ready);
endinterface

// File: rtl/core/dds_out_if.sv
// Result channel of the digit sprite emitter, one request per digit.
// Depends on dds_pkg for field widths.
interface dds_out_if import dds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DX_W-1:0]  dest_x;
  logic signed [POS_W-1:0] dest_y;
  logic [SRC_X_W-1:0]      src_x;
  logic [ORIGIN_W-1:0]     src_y;
  logic [DIGIT_W-1:0]      digit;
  logic                    visible;
  logic                    last;

  modport source (output valid, dest_x, dest_y, src_x, src_y, digit, visible, last,
                  input ready);
  modport sink   (input valid, dest_x, dest_y, src_x, src_y, digit, visible, last,
                  output ready);
endinterface

// File: rtl/core/dds_cfg_if.sv
// Configuration write channel of the digit sprite emitter.
// Depends on dds_pkg for index and data widths.
interface dds_cfg_if import dds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/dds_ctrl.sv
// Controller FSM: sequences load, binary-to-BCD conversion and digit emission.
// Depends on dds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dds_ctrl import dds_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  dds_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.cnt_zero) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if ((!out_valid_r || out_ready) && sts.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_load = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  // Output register valid: set on a load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_load)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `DDS_ASSERT(a_emit_after_conv, clk, rst_n, (state_r == ST_EMIT && $past(state_r) == ST_CONV) |-> $past(sts.conv_last), "emit entered before conversion finished")
  `DDS_ASSERT(a_valid_from_emit, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_EMIT, "result raised outside emission")
  `DDS_ASSERT(a_leave_on_last, clk, rst_n, ($past(state_r) == ST_EMIT && state_r == ST_IDLE) |-> $past(cmd.emit_load && sts.emit_last), "emission ended before last digit")
  `DDS_ASSERT_NR(a_reset_clears, clk, (!rst_n) |=> !out_valid_r, "result valid after reset")

endmodule

// File: rtl/core/dds_dp.sv
// Datapath: config registers, double-dabble BCD converter, digit output register.
// Depends on dds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dds_dp import dds_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_sts_t                     sts,
  input  logic                        cfg_we,
  input  cfg_reg_t                    cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [BIN_W-1:0]     in_number,
  input  logic [CNT_W-1:0]            in_digit_count,
  input  logic signed [POS_W-1:0]     in_pos_x,
  input  logic signed [POS_W-1:0]     in_pos_y,
  output logic signed [DX_W-1:0]      out_dest_x,
  output logic signed [POS_W-1:0]     out_dest_y,
  output logic [SRC_X_W-1:0]          out_src_x,
  output logic [ORIGIN_W-1:0]         out_src_y,
  output logic [DIGIT_W-1:0]          out_digit,
  output logic                        out_visible,
  output logic                        out_last
);

  localparam int POS_IDX_W = $clog2(MAX_DIGITS);

  // Configuration registers
  logic [GLYPH_W-1:0]  glyph_width_r, glyph_height_r;
  logic [ORIGIN_W-1:0] strip_x_r, strip_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= GLYPH_W'(8);
      glyph_height_r <= GLYPH_W'(8);
      strip_x_r      <= '0;
      strip_y_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[GLYPH_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[GLYPH_W-1:0];
        REG_STRIP_X:      strip_x_r      <= cfg_data[ORIGIN_W-1:0];
        REG_STRIP_Y:      strip_y_r      <= cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic [BIN_W-1:0]         bin_r, bin_nxt;
  logic [DIGIT_W-1:0]       bcd_r [MAX_DIGITS];
  logic [DIGIT_W-1:0]       bcd_nxt [MAX_DIGITS];
  logic [BIT_CNT_W-1:0]     bitcnt_r;
  logic [POS_IDX_W-1:0]     pos_r;
  logic signed [DX_W-1:0]   dx_r;
  logic signed [POS_W-1:0]  py_r;

  // Magnitude and saturated digit count of the incoming request
  logic [BIN_W-1:0] mag;
  logic [CNT_W-1:0] cnt_sat;

  always_comb begin
    mag     = in_number[BIN_W-1] ? BIN_W'(-in_number) : BIN_W'(in_number);
    cnt_sat = (in_digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : in_digit_count;
  end

  // Double-dabble step: add 3 to digits of 5 or more, then shift in one bit
  logic [DIGIT_W-1:0] adj [MAX_DIGITS];

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= DIGIT_W'(5)) ? bcd_r[i] + DIGIT_W'(3) : bcd_r[i];
    end
    bcd_nxt[0] = {adj[0][DIGIT_W-2:0], bin_r[BIN_W-1]};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      bcd_nxt[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
    end
    bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r    <= mag;
      bitcnt_r <= '0;
      pos_r    <= POS_IDX_W'(cnt_sat - CNT_W'(1));
      dx_r     <= DX_W'(in_pos_x);
      py_r     <= in_pos_y;
      for (int i = 0; i < MAX_DIGITS; i++) bcd_r[i] <= '0;
    end else if (cmd.conv_step) begin
      bin_r    <= bin_nxt;
      bitcnt_r <= bitcnt_r + BIT_CNT_W'(1);
      for (int i = 0; i < MAX_DIGITS; i++) bcd_r[i] <= bcd_nxt[i];
    end else if (cmd.emit_load) begin
      pos_r <= pos_r - POS_IDX_W'(1);
      dx_r  <= dx_r + $signed(DX_W'(glyph_width_r));
    end
  end

  // Per-digit result: glyph source, cull test
  logic [DIGIT_W-1:0]      cur_digit;
  logic [SRC_X_W-1:0]      src_x;
  logic signed [DX_W:0]    right_x;
  logic signed [POS_W:0]   bottom_y;
  logic                    hidden;

  always_comb begin
    cur_digit = bcd_r[pos_r];
    // product kept at full source width before the origin is added
    src_x     = SRC_X_W'(strip_x_r) + SRC_X_W'(glyph_width_r) * SRC_X_W'(cur_digit);
    right_x   = $signed({dx_r[DX_W-1], dx_r}) + $signed((DX_W+1)'(glyph_width_r));
    bottom_y  = $signed({py_r[POS_W-1], py_r}) + $signed((POS_W+1)'(glyph_height_r));
    hidden    = (dx_r > $signed(DX_W'(WINDOW_WIDTH))) || (right_x < 0) ||
                (py_r > $signed(POS_W'(WINDOW_HEIGHT))) || (bottom_y < 0);
  end

  // Output register
  logic signed [DX_W-1:0]  dest_x_r;
  logic signed [POS_W-1:0] dest_y_r;
  logic [SRC_X_W-1:0]      src_x_r;
  logic [ORIGIN_W-1:0]     src_y_r;
  logic [DIGIT_W-1:0]      digit_r;
  logic                    visible_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      dest_x_r  <= dx_r;
      dest_y_r  <= py_r;
      src_x_r   <= src_x;
      src_y_r   <= strip_y_r;
      digit_r   <= cur_digit;
      visible_r <= !hidden;
      last_r    <= (pos_r == '0);
    end
  end

  assign out_dest_x  = dest_x_r;
  assign out_dest_y  = dest_y_r;
  assign out_src_x   = src_x_r;
  assign out_src_y   = src_y_r;
  assign out_digit   = digit_r;
  assign out_visible = visible_r;
  assign out_last    = last_r;

  // Status to controller
  always_comb begin
    sts.cnt_zero  = (in_digit_count == '0);
    sts.conv_last = (bitcnt_r == BIT_CNT_W'(BIN_W-1));
    sts.emit_last = (pos_r == '0);
  end

  `DDS_ASSERT(a_digit_decimal, clk, rst_n, $past(cmd.emit_load) |-> digit_r <= DIGIT_W'(9), "converter produced a non-decimal digit")

endmodule

// File: rtl/core/decimal_digit_sprite_emitter.sv
// Top level of the decimal digit sprite emitter.
// Depends on dds_pkg, the three channel interfaces, dds_ctrl and dds_dp.
//
// Usage:
//   in_ch  : one request carries number, digit_count, pos_x and pos_y. It is
//            taken whenever the block is idle, even while a result still waits.
//   out_ch : one request per displayed digit, most significant first, with
//            screen and strip positions, a cull flag and last on the final digit.
//   cfg_ch : register writes (glyph width/height, strip origin x/y), always
//            ready; write only while no request is in flight.
// Conversion and throughput:
//   The magnitude is converted by a 32-step shift-and-add-3 loop, one bit per
//   cycle, before the first digit is loaded into the output register. Further
//   digits follow one per cycle while out_ch.ready is not held low. A new
//   request is taken only once the last digit is loaded; a zero count is
//   taken while idle and gives no result.
// Reset: synchronous, active low; clears the controller, drops out_ch.valid and
//   loads the register defaults (glyph 8x8, strip origin 0,0).
// Stall: a held out_ch.ready freezes the output register and the emission of
//   further digits; no digit is lost or repeated.
module decimal_digit_sprite_emitter import dds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dds_in_if.sink    in_ch,
  dds_out_if.source out_ch,
  dds_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  dds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dds_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_reg_t'(cfg_ch.index)),
    .cfg_data       (cfg_ch.data),
    .in_number      (in_ch.number),
    .in_digit_count (in_ch.digit_count),
    .in_pos_x       (in_ch.pos_x),
    .in_pos_y       (in_ch.pos_y),
    .out_dest_x     (out_ch.dest_x),
    .out_dest_y     (out_ch.dest_y),
    .out_src_x      (out_ch.src_x),
    .out_src_y      (out_ch.src_y),
    .out_digit      (out_ch.digit),
    .out_visible    (out_ch.visible),
    .out_last       (out_ch.last)
  );

endmodule

// File: bench/dds_glyph_checker.sv
`timescale 1ns / 1ps
// Checker for the decimal digit sprite emitter: watches all three channels.
// Predicts the per-digit glyph requests and compares them in order.
// Depends on dds_pkg and the dds_in_if, dds_out_if and dds_cfg_if interfaces.
module dds_glyph_checker import dds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dds_in_if    in_ch,
  dds_out_if   out_ch,
  dds_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  // One expected glyph request
  typedef struct packed {
    logic [DX_W-1:0]     dest_x;
    logic [POS_W-1:0]    dest_y;
    logic [SRC_X_W-1:0]  src_x;
    logic [ORIGIN_W-1:0] src_y;
    logic [DIGIT_W-1:0]  digit;
    logic                visible;
    logic                last;
  } glyph_t;

  glyph_t glyph_queue[$];

  // Shadow copy of the configuration registers
  int glyph_w;
  int glyph_h;
  int strip_x;
  int strip_y;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    glyph_t            want;
    glyph_t            got;
    logic [BIN_W-1:0]  magnitude;
    longint unsigned   rest;
    int                bcd[MAX_DIGITS];
    int                n;
    int                px;
    int                py;
    int                dx;

    if (!rst_n) begin
      glyph_w    = 8;
      glyph_h    = 8;
      strip_x    = 0;
      strip_y    = 0;
      fail_count = 0;
      glyph_queue.delete();
    end else begin
      // Register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_GLYPH_WIDTH:  glyph_w = int'(cfg_ch.data[GLYPH_W-1:0]);
          REG_GLYPH_HEIGHT: glyph_h = int'(cfg_ch.data[GLYPH_W-1:0]);
          REG_STRIP_X:      strip_x = int'(cfg_ch.data[ORIGIN_W-1:0]);
          REG_STRIP_Y:      strip_y = int'(cfg_ch.data[ORIGIN_W-1:0]);
          default: ;
        endcase
      end

      // Compare a delivered glyph against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.dest_x, out_ch.dest_y, out_ch.src_x, out_ch.src_y,
                out_ch.digit, out_ch.visible, out_ch.last};
        if (glyph_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected glyph request %h", got));
        end else begin
          want = glyph_queue.pop_front();
          if (got.dest_x !== want.dest_x)
            report_mismatch($sformatf("dest_x %h, want %h", got.dest_x, want.dest_x));
          if (got.dest_y !== want.dest_y)
            report_mismatch($sformatf("dest_y %h, want %h", got.dest_y, want.dest_y));
          if (got.src_x !== want.src_x)
            report_mismatch($sformatf("src_x %h, want %h", got.src_x, want.src_x));
          if (got.src_y !== want.src_y)
            report_mismatch($sformatf("src_y %h, want %h", got.src_y, want.src_y));
          if (got.digit !== want.digit)
            report_mismatch($sformatf("digit %h, want %h", got.digit, want.digit));
          if (got.visible !== want.visible)
            report_mismatch($sformatf("visible %b, want %b", got.visible, want.visible));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end

      // Predict the glyphs of an accepted request
      if (in_ch.valid && in_ch.ready) begin
        magnitude = in_ch.number[BIN_W-1] ? (~in_ch.number + 1'b1) : in_ch.number;
        n  = (in_ch.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(in_ch.digit_count);
        px = in_ch.pos_x;
        py = in_ch.pos_y;
        rest = magnitude;
        for (int p = 0; p < MAX_DIGITS; p++) begin
          bcd[p] = int'(rest % 10);
          rest   = rest / 10;
        end
        // leftmost glyph first; digits above the count are dropped
        for (int k = 0; k < n; k++) begin
          dx = px + glyph_w * k;
          want.dest_x  = DX_W'(dx);
          want.dest_y  = POS_W'(py);
          want.digit   = DIGIT_W'(bcd[n-1-k]);
          want.src_x   = SRC_X_W'(strip_x + glyph_w * bcd[n-1-k]);
          want.src_y   = ORIGIN_W'(strip_y);
          want.visible = !(dx > WINDOW_WIDTH || dx + glyph_w < 0 ||
                           py > WINDOW_HEIGHT || py + glyph_h < 0);
          want.last    = (k == n - 1);
          glyph_queue.push_back(want);
        end
      end
    end
    pending = glyph_queue.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the digit sprite emitter bench: clock, reset, stimulus and verdict.
// Depends on dds_pkg, the channel interfaces, the block and dds_glyph_checker.
module tb_top;
  import dds_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_OFF_LEN = 300;
  localparam int SETTLE_LEN   = 40;

  logic clk;
  logic rst_n;

  dds_in_if  in_ch();
  dds_out_if out_ch();
  dds_cfg_if cfg_ch();

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Idle percentages for each side, changed per phase
  int send_idle_pct;
  int recv_stall_pct;

  // Long receiver hold-off, requested by flipping hold_toggle
  logic hold_toggle;
  logic hold_seen;
  int   hold_cycles;

  decimal_digit_sprite_emitter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dds_glyph_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= hold_toggle;
      hold_cycles  <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen    <= hold_toggle;
      hold_cycles  <= HOLD_OFF_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request, idling at random beforehand
  task automatic send_request(input logic [BIN_W-1:0] number, input logic [CNT_W-1:0] count,
                              input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.number      <= number;
    in_ch.digit_count <= count;
    in_ch.pos_x       <= px;
    in_ch.pos_y       <= py;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every predicted glyph has been delivered
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // a zero-count request may still be in flight
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers; only called while the block is idle
  task automatic configure(input logic [CFG_DATA_W-1:0] gw, input logic [CFG_DATA_W-1:0] gh,
                           input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy);
    cfg_reg_t                regs[4];
    logic [CFG_DATA_W-1:0]   vals[4];
    regs = '{REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT, REG_STRIP_X, REG_STRIP_Y};
    vals = '{gw, gh, sx, sy};
    for (int r = 0; r < 4; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[r];
      cfg_ch.data  <= vals[r];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random requests: mixed magnitudes, counts and positions around the window
  task automatic send_random_batch(input int count);
    logic [BIN_W-1:0] number;
    logic [CNT_W-1:0] digits;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    longint unsigned  scale;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: number = $urandom();
        1: number = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: begin
          scale = 1;
          repeat ($urandom_range(10, 1)) scale = scale * 10;
          number = BIN_W'($urandom() % scale);
          if ($urandom_range(1)) number = -number;
        end
      endcase
      case ($urandom_range(9))
        0:       digits = '0;
        1:       digits = CNT_W'($urandom_range(15, MAX_DIGITS + 1));
        default: digits = CNT_W'($urandom_range(MAX_DIGITS, 1));
      endcase
      px = ($urandom_range(3) == 0) ? POS_W'($urandom()) : POS_W'(int'($urandom_range(420)) - 60);
      py = ($urandom_range(3) == 0) ? POS_W'($urandom()) : POS_W'(int'($urandom_range(320)) - 40);
      send_request(number, digits, px, py);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    hold_toggle        <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.number       <= '0;
    in_ch.digit_count  <= '0;
    in_ch.pos_x        <= '0;
    in_ch.pos_y        <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    send_idle_pct      = 15;
    recv_stall_pct     = 82;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset configuration (8x8 glyphs, origin 0,0)
    send_request(32'd0,          4'd1,  16'sd0,      16'sd0);
    send_request(32'h7FFF_FFFF,  4'd10, 16'sd10,     16'sd10);
    send_request(32'h8000_0001,  4'd10, 16'sd0,      16'sd100);
    send_request(32'h8000_0000,  4'd10, -16'sd32768, -16'sd32768);
    send_request(32'd12345,      4'd3,  16'sd50,     16'sd50);   // high digits dropped
    send_request(32'd12345,      4'd0,  16'sd50,     16'sd50);   // no glyphs
    send_request(32'd987654321,  4'd15, 16'sd0,      16'sd0);    // count saturates
    send_request(32'hFFFF_FFFF,  4'd11, 16'sd0,      16'sd0);
    send_request(32'd7,          4'd5,  16'sd320,    16'sd240);  // on the window edge
    send_request(32'd7,          4'd1,  16'sd321,    16'sd0);
    send_request(32'd3,          4'd1,  -16'sd8,     16'sd0);    // right edge at zero
    send_request(32'd3,          4'd1,  -16'sd9,     16'sd0);
    send_request(32'd4,          4'd1,  16'sd0,      16'sd241);
    send_request(32'd4,          4'd1,  16'sd0,      -16'sd8);
    send_request(32'd4,          4'd1,  16'sd0,      -16'sd9);
    send_request(32'd55,         4'd2,  16'sd32767,  16'sd32767);
    send_request(32'd1234567890, 4'd10, -16'sd40,    16'sd5);    // first glyphs culled
    send_request(32'd0,          4'd0,  16'sd0,      16'sd0);
    send_request(32'd1000000000, 4'd10, 16'sd300,    16'sd200);
    send_request(-32'sd99,       4'd8,  16'sd100,    -16'sd1);
    drain();

    // Sender mostly busy, receiver mostly stalled
    configure(12'd12, 12'd16, 12'h100, 12'h0A5);
    send_idle_pct  = 15;
    recv_stall_pct = 82;
    send_random_batch(35);
    drain();

    // Largest glyphs and origin; upper data bits are dropped by the glyph size registers
    configure(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_idle_pct  = 82;
    recv_stall_pct = 15;
    send_random_batch(30);
    drain();

    // Zero-size glyphs, no idling; long receiver hold-off fills the block
    configure(12'h000, 12'h000, 12'h000, 12'h000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_toggle <= ~hold_toggle;
    send_random_batch(15);
    drain();
    configure(12'd8, 12'd8, 12'h5A3, 12'hA5C);
    send_random_batch(15);
    drain();

    repeat (SETTLE_LEN) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dds_pkg.sv
rtl/core/dds_in_if.sv
rtl/core/dds_out_if.sv
rtl/core/dds_cfg_if.sv
rtl/core/dds_ctrl.sv
rtl/core/dds_dp.sv
rtl/core/decimal_digit_sprite_emitter.sv
bench/dds_glyph_checker.sv
bench/tb_top.sv
